// ===== rtl/msa_trd_pkg.sv =====
// Shared types and constants for the MSA track RLE decoder.
// No dependencies; the output interface, the decoder and the bench import this package.
package msa_trd_pkg;

  localparam int unsigned SECTOR_BYTES  = 512;
  localparam int unsigned MAX_SECTORS   = 56;
  localparam int unsigned MAX_END_TRACK = 86;

  localparam logic [15:0] MSA_ID   = 16'h0E0F;
  localparam logic [7:0]  RUN_MARK = 8'hE5;

  // Header byte positions: odd positions complete a big-endian word
  localparam logic [3:0] HDR_IDX_FIRST   = 4'd0;
  localparam logic [3:0] HDR_IDX_ID      = 4'd1;
  localparam logic [3:0] HDR_IDX_SECT    = 4'd3;
  localparam logic [3:0] HDR_IDX_SIDES   = 4'd5;
  localparam logic [3:0] HDR_IDX_START   = 4'd7;
  localparam logic [3:0] HDR_IDX_END     = 4'd9;
  localparam logic [3:0] HDR_IDX_DISCARD = 4'd10;

  typedef enum logic [1:0] {
    ST_DATA       = 2'd0,
    ST_BAD_HEADER = 2'd1,
    ST_EARLY_END  = 2'd2,
    ST_EMPTY_DONE = 2'd3
  } status_t;

  typedef enum logic [7:0] {
    PH_HEADER  = 8'b0000_0001,
    PH_LEN_HI  = 8'b0000_0010,
    PH_LEN_LO  = 8'b0000_0100,
    PH_COPY    = 8'b0000_1000,
    PH_RLE     = 8'b0001_0000,
    PH_RUN_VAL = 8'b0010_0000,
    PH_RUN_HI  = 8'b0100_0000,
    PH_RUN_LO  = 8'b1000_0000
  } phase_t;

endpackage

// ===== rtl/msa_trd_if.sv =====
// Valid/ready channel interfaces for the decoder's byte input and result output.
// Depends on msa_trd_pkg for the status type.
interface msa_trd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       file_last;

  modport source (output valid, output in_byte, output file_last, input ready);
  modport sink   (input valid, input in_byte, input file_last, output ready);
endinterface

interface msa_trd_out_if import msa_trd_pkg::*; ;
  logic        valid;
  logic        ready;
  status_t     status;
  logic [7:0]  data_byte;
  logic [14:0] repeat_count;
  logic        run_clipped;
  logic [6:0]  track_number;
  logic        side_number;
  logic        track_last;
  logic        image_last;

  modport source (output valid, output status, output data_byte, output repeat_count,
                  output run_clipped, output track_number, output side_number,
                  output track_last, output image_last, input ready);
  modport sink   (input valid, input status, input data_byte, input repeat_count,
                  input run_clipped, input track_number, input side_number,
                  input track_last, input image_last, output ready);
endinterface

// ===== rtl/msa_track_rle_decoder.sv =====
// Streaming MSA disk-image decoder: header check, per-track copy or RLE decode.
// Depends on msa_trd_pkg and the channel interfaces in msa_trd_if.sv.

// Takes one file byte per clock and gives at most one result per byte. A byte
// is held in an input register, decoded against the parse state, and its
// result lands in an output register, so the sustained rate is one byte per
// cycle while out_ch.ready stays high. Runs come out as (byte, count) pairs;
// a run longer than the rest of the track is cut and flagged. A bad or short
// header gives a bad-header result, a file that ends inside the image gives a
// premature-end result, and bytes after the image are dropped until the byte
// flagged file_last, which rearms the parser.
module msa_track_rle_decoder
  import msa_trd_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  msa_trd_in_if.sink    in_ch,
  msa_trd_out_if.source out_ch
);

  // input register
  logic        iv_r;
  logic [7:0]  ib_r;
  logic        il_r;
  logic        advance;
  logic        step;

  // parse state
  phase_t      phase_r, phase_nxt;
  logic [3:0]  hidx_r, hidx_nxt;
  logic [7:0]  pend_r, pend_nxt;
  logic        ok_r, ok_nxt;
  logic [5:0]  sect_r, sect_nxt;
  logic        ds_r, ds_nxt;
  logic [6:0]  trk_r, trk_nxt;
  logic [6:0]  final_r, final_nxt;
  logic        side_r, side_nxt;
  logic [14:0] bd_r, bd_nxt;
  logic [7:0]  runv_r, runv_nxt;

  // result register
  logic        ov_r;
  status_t     ost_r, ost_nxt;
  logic [7:0]  odb_r, odb_nxt;
  logic [14:0] orep_r, orep_nxt;
  logic        oclip_r, oclip_nxt;
  logic [6:0]  otrk_r, otrk_nxt;
  logic        oside_r, oside_nxt;
  logic        otl_r, otl_nxt;
  logic        oil_r, oil_nxt;
  logic        emit;

  // combinational helpers
  logic [15:0] word;
  logic [14:0] per;
  logic [14:0] left;
  logic        fin_done;
  logic        fin_side;
  logic [6:0]  fin_trk;
  logic        do_data;
  logic [7:0]  d_val;
  logic [14:0] d_cnt;
  logic        d_clip;
  logic [15:0] bd_sum;
  logic        ok_cur;

  assign advance     = !ov_r || out_ch.ready;
  assign step        = iv_r && advance;
  assign in_ch.ready = !iv_r || advance;

  assign word     = {pend_r, ib_r};
  assign per      = 15'(sect_r * SECTOR_BYTES);
  assign left     = (per > bd_r) ? (per - bd_r) : '0;
  assign fin_done = (trk_r == final_r) && (side_r || !ds_r);
  assign fin_side = ds_r && !side_r;
  assign fin_trk  = fin_side ? trk_r : trk_r + 7'd1;
  assign bd_sum   = {1'b0, bd_r} + {1'b0, d_cnt};

  always_comb begin
    phase_nxt = phase_r;
    hidx_nxt  = hidx_r;
    pend_nxt  = pend_r;
    ok_nxt    = ok_r;
    sect_nxt  = sect_r;
    ds_nxt    = ds_r;
    trk_nxt   = trk_r;
    final_nxt = final_r;
    side_nxt  = side_r;
    bd_nxt    = bd_r;
    runv_nxt  = runv_r;
    emit      = 1'b0;
    ost_nxt   = ST_DATA;
    odb_nxt   = '0;
    orep_nxt  = '0;
    oclip_nxt = 1'b0;
    otrk_nxt  = '0;
    oside_nxt = 1'b0;
    otl_nxt   = 1'b0;
    oil_nxt   = 1'b0;
    do_data   = 1'b0;
    d_val     = ib_r;
    d_cnt     = 15'd1;
    d_clip    = 1'b0;
    ok_cur    = ok_r;

    unique case (phase_r)
      PH_HEADER: begin
        if (hidx_r < HDR_IDX_DISCARD) begin
          ok_cur = (hidx_r == HDR_IDX_FIRST) ? 1'b1 : ok_r;
          if (!hidx_r[0]) begin
            pend_nxt = ib_r;
          end else begin
            priority case (hidx_r)
              HDR_IDX_ID: begin
                if (word != MSA_ID) ok_cur = 1'b0;
              end
              HDR_IDX_SECT: begin
                if (word > 16'(MAX_SECTORS)) ok_cur = 1'b0;
                sect_nxt = word[5:0];
              end
              HDR_IDX_SIDES: begin
                if (word > 16'd1) ok_cur = 1'b0;
                ds_nxt = word[0];
              end
              HDR_IDX_START: begin
                if (word > 16'(MAX_END_TRACK)) ok_cur = 1'b0;
                trk_nxt = word[6:0];
              end
              default: begin
                if (word > 16'(MAX_END_TRACK) || trk_r > word[6:0]) ok_cur = 1'b0;
                final_nxt = word[6:0];
              end
            endcase
          end
          ok_nxt = ok_cur;
          if (il_r || (hidx_r == HDR_IDX_END && !ok_cur)) begin
            hidx_nxt = HDR_IDX_DISCARD;
            emit     = 1'b1;
            ost_nxt  = ST_BAD_HEADER;
          end else if (hidx_r == HDR_IDX_END) begin
            side_nxt  = 1'b0;
            bd_nxt    = '0;
            phase_nxt = PH_LEN_HI;
            hidx_nxt  = HDR_IDX_FIRST;
          end else begin
            hidx_nxt = hidx_r + 4'd1;
          end
        end
      end
      PH_LEN_HI: begin
        pend_nxt  = ib_r;
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        bd_nxt = '0;
        if (per == '0) begin
          // empty track: close it at the length word
          side_nxt = fin_side;
          trk_nxt  = fin_trk;
          if (fin_done) begin
            phase_nxt = PH_HEADER;
            hidx_nxt  = HDR_IDX_DISCARD;
            emit      = 1'b1;
            ost_nxt   = ST_EMPTY_DONE;
            otrk_nxt  = trk_r;
            oside_nxt = side_r;
            otl_nxt   = 1'b1;
            oil_nxt   = 1'b1;
          end else begin
            phase_nxt = PH_LEN_HI;
          end
        end else begin
          phase_nxt = (word == {1'b0, per}) ? PH_COPY : PH_RLE;
        end
      end
      PH_COPY: begin
        do_data = 1'b1;
      end
      PH_RLE: begin
        if (ib_r != RUN_MARK) begin
          do_data = 1'b1;
        end else begin
          phase_nxt = PH_RUN_VAL;
        end
      end
      PH_RUN_VAL: begin
        runv_nxt  = ib_r;
        phase_nxt = PH_RUN_HI;
      end
      PH_RUN_HI: begin
        pend_nxt  = ib_r;
        phase_nxt = PH_RUN_LO;
      end
      PH_RUN_LO: begin
        phase_nxt = PH_RLE;
        d_val     = runv_r;
        if (word > {1'b0, left}) begin
          d_cnt  = left;
          d_clip = 1'b1;
        end else begin
          d_cnt = word[14:0];
        end
        do_data = (d_cnt != '0);
      end
      default: begin
        phase_nxt = PH_HEADER;
      end
    endcase

    if (do_data) begin
      emit      = 1'b1;
      ost_nxt   = ST_DATA;
      odb_nxt   = d_val;
      orep_nxt  = d_cnt;
      oclip_nxt = d_clip;
      otrk_nxt  = trk_r;
      oside_nxt = side_r;
      if (bd_sum >= {1'b0, per}) begin
        // track full: move to the next side or track
        otl_nxt  = 1'b1;
        oil_nxt  = fin_done;
        side_nxt = fin_side;
        trk_nxt  = fin_trk;
        bd_nxt   = '0;
        if (fin_done) begin
          phase_nxt = PH_HEADER;
          hidx_nxt  = HDR_IDX_DISCARD;
        end else begin
          phase_nxt = PH_LEN_HI;
        end
      end else begin
        bd_nxt = bd_sum[14:0];
      end
    end

    if (il_r) begin
      if (phase_nxt != PH_HEADER) begin
        // file ended inside the image: replace any data result
        emit      = 1'b1;
        ost_nxt   = ST_EARLY_END;
        odb_nxt   = '0;
        orep_nxt  = '0;
        oclip_nxt = 1'b0;
        otrk_nxt  = '0;
        oside_nxt = 1'b0;
        otl_nxt   = 1'b0;
        oil_nxt   = 1'b0;
      end
      phase_nxt = PH_HEADER;
      hidx_nxt  = HDR_IDX_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r    <= 1'b0;
      ov_r    <= 1'b0;
      phase_r <= PH_HEADER;
      hidx_r  <= HDR_IDX_FIRST;
      pend_r  <= '0;
      ok_r    <= 1'b0;
      sect_r  <= '0;
      ds_r    <= 1'b0;
      trk_r   <= '0;
      final_r <= '0;
      side_r  <= 1'b0;
      bd_r    <= '0;
      runv_r  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        iv_r <= 1'b1;
      end else if (advance) begin
        iv_r <= 1'b0;
      end
      if (step) begin
        ov_r    <= emit;
        phase_r <= phase_nxt;
        hidx_r  <= hidx_nxt;
        pend_r  <= pend_nxt;
        ok_r    <= ok_nxt;
        sect_r  <= sect_nxt;
        ds_r    <= ds_nxt;
        trk_r   <= trk_nxt;
        final_r <= final_nxt;
        side_r  <= side_nxt;
        bd_r    <= bd_nxt;
        runv_r  <= runv_nxt;
      end else if (out_ch.ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      ib_r <= in_ch.in_byte;
      il_r <= in_ch.file_last;
    end
    if (step && emit) begin
      ost_r   <= ost_nxt;
      odb_r   <= odb_nxt;
      orep_r  <= orep_nxt;
      oclip_r <= oclip_nxt;
      otrk_r  <= otrk_nxt;
      oside_r <= oside_nxt;
      otl_r   <= otl_nxt;
      oil_r   <= oil_nxt;
    end
  end

  assign out_ch.valid        = ov_r;
  assign out_ch.status       = ost_r;
  assign out_ch.data_byte    = odb_r;
  assign out_ch.repeat_count = orep_r;
  assign out_ch.run_clipped  = oclip_r;
  assign out_ch.track_number = otrk_r;
  assign out_ch.side_number  = oside_r;
  assign out_ch.track_last   = otl_r;
  assign out_ch.image_last   = oil_r;

`ifndef SYNTHESIS
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (iv_r && ov_r && !out_ch.ready))
    else $error("input stalled while pipeline has room");

  a_data_has_count: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && ost_r == ST_DATA) |-> (orep_r != '0))
    else $error("data result with zero repeat count");

  a_image_closes_track: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && oil_r) |-> otl_r)
    else $error("image end without track end");

  a_error_fields_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && (ost_r == ST_BAD_HEADER || ost_r == ST_EARLY_END)) |->
      (orep_r == '0 && otrk_r == '0 && !otl_r && !oil_r && !oclip_r))
    else $error("error result carries data fields");

  a_track_bytes_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_COPY || phase_r == PH_RLE) |-> (bd_r < per))
    else $error("track byte count reached track size without closing");
`endif

endmodule

// ===== verif/tb_msa_track_rle_decoder.sv =====
`timescale 1ns / 100ps
// Self-checking bench for msa_track_rle_decoder: streams MSA image files and
// checks every decoded run against an in-bench decoder. Needs msa_trd_pkg and
// the channel interfaces from rtl/msa_trd_if.sv.
module tb_msa_track_rle_decoder;
  import msa_trd_pkg::*;

  localparam int unsigned ITEM_TARGET = 1550;
  localparam int unsigned QUIET_TAIL  = 150;
  localparam int unsigned STALL_LIMIT = 2000;

  typedef struct packed {
    status_t     status;
    logic [7:0]  data_byte;
    logic [14:0] repeat_count;
    logic        run_clipped;
    logic [6:0]  track_number;
    logic        side_number;
    logic        track_last;
    logic        image_last;
  } disk_run_t;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         hold;  // wait for all outstanding runs before sending
  } file_byte_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msa_trd_in_if  in_ch ();
  msa_trd_out_if out_ch ();

  msa_track_rle_decoder uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  file_byte_t  pend[$];
  logic [7:0]  file_bytes[$];
  disk_run_t   runs_due[$];

  bit          in_took;
  int unsigned in_gap, out_gap;
  int unsigned in_rate = 2, out_rate = 2;
  int unsigned fails, quiet_cycles, bytes_in, runs_out, files;
  int unsigned n_data, n_clip, n_bad, n_early, n_empty;

  // Decoder state, mirrors the block after reset
  phase_t      ph = PH_HEADER;
  logic [3:0]  hdr_idx = HDR_IDX_FIRST;
  logic [7:0]  hi_byte = 8'd0;
  logic        hdr_ok = 1'b0;
  logic [5:0]  n_sect = 6'd0;
  logic        two_sided = 1'b0;
  logic [6:0]  trk = 7'd0;
  logic [6:0]  end_trk = 7'd0;
  logic        side = 1'b0;
  int unsigned fill = 0;
  logic [7:0]  rval = 8'd0;

  task automatic close_track(output bit img_done);
    img_done = (trk == end_trk) && (side || !two_sided);
    if (two_sided && !side) begin
      side = 1'b1;
    end else begin
      side = 1'b0;
      trk = trk + 7'd1;
    end
    fill = 0;
    if (img_done) begin
      ph = PH_HEADER;
      hdr_idx = HDR_IDX_DISCARD;
    end else begin
      ph = PH_LEN_HI;
    end
  endtask

  task automatic put_run(input logic [7:0] v, input int unsigned cnt, input bit clip,
                         output disk_run_t r);
    logic [6:0] t;
    logic       s;
    bit         tl, il;
    t = trk;
    s = side;
    tl = 1'b0;
    il = 1'b0;
    fill += cnt;
    if (fill >= SECTOR_BYTES * n_sect) begin
      tl = 1'b1;
      close_track(il);
    end
    r = '{ST_DATA, v, 15'(cnt), clip, t, s, tl, il};
  endtask

  task automatic take_header(input logic [7:0] b, input logic last, output bit got,
                             output disk_run_t r);
    logic [15:0] w;
    w = {hi_byte, b};
    got = 1'b0;
    if (hdr_idx >= HDR_IDX_DISCARD) return;
    if (hdr_idx == HDR_IDX_FIRST) hdr_ok = 1'b1;
    if (!hdr_idx[0]) begin
      hi_byte = b;
    end else begin
      case (hdr_idx)
        HDR_IDX_ID: begin
          if (w != MSA_ID) hdr_ok = 1'b0;
        end
        HDR_IDX_SECT: begin
          if (w > MAX_SECTORS) hdr_ok = 1'b0;
          n_sect = w[5:0];
        end
        HDR_IDX_SIDES: begin
          if (w > 1) hdr_ok = 1'b0;
          two_sided = w[0];
        end
        HDR_IDX_START: begin
          if (w > MAX_END_TRACK) hdr_ok = 1'b0;
          trk = w[6:0];
        end
        default: begin
          if (w > MAX_END_TRACK || trk > w[6:0]) hdr_ok = 1'b0;
          end_trk = w[6:0];
        end
      endcase
    end
    if (last || (hdr_idx == HDR_IDX_END && !hdr_ok)) begin
      hdr_idx = HDR_IDX_DISCARD;
      got = 1'b1;
      r = '{ST_BAD_HEADER, 8'd0, 15'd0, 1'b0, 7'd0, 1'b0, 1'b0, 1'b0};
      return;
    end
    if (hdr_idx == HDR_IDX_END) begin
      side = 1'b0;
      fill = 0;
      ph = PH_LEN_HI;
      hdr_idx = HDR_IDX_FIRST;
    end else begin
      hdr_idx = hdr_idx + 4'd1;
    end
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic last, output bit got,
                             output disk_run_t r);
    int unsigned per, cnt, room;
    bit          clip, done;
    logic [6:0]  t;
    logic        s;
    per = SECTOR_BYTES * n_sect;
    got = 1'b0;
    r = '0;
    case (ph)
      PH_HEADER: begin
        take_header(b, last, got, r);
        if (last) hdr_idx = HDR_IDX_FIRST;
        return;
      end
      PH_LEN_HI: begin
        hi_byte = b;
        ph = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        fill = 0;
        if (per == 0) begin
          // empty tracks: only the final one reports
          t = trk;
          s = side;
          close_track(done);
          if (done) begin
            got = 1'b1;
            r = '{ST_EMPTY_DONE, 8'd0, 15'd0, 1'b0, t, s, 1'b1, 1'b1};
          end
        end else begin
          ph = ({hi_byte, b} == per) ? PH_COPY : PH_RLE;
        end
      end
      PH_COPY: begin
        put_run(b, 1, 1'b0, r);
        got = 1'b1;
      end
      PH_RLE: begin
        if (b != RUN_MARK) begin
          put_run(b, 1, 1'b0, r);
          got = 1'b1;
        end else begin
          ph = PH_RUN_VAL;
        end
      end
      PH_RUN_VAL: begin
        rval = b;
        ph = PH_RUN_HI;
      end
      PH_RUN_HI: begin
        hi_byte = b;
        ph = PH_RUN_LO;
      end
      default: begin
        cnt = 32'({hi_byte, b});
        room = (per > fill) ? per - fill : 0;
        clip = 1'b0;
        ph = PH_RLE;
        if (cnt > room) begin
          cnt = room;
          clip = 1'b1;
        end
        if (cnt != 0) begin
          put_run(rval, cnt, clip, r);
          got = 1'b1;
        end
      end
    endcase
    if (last) begin
      if (ph != PH_HEADER) begin
        got = 1'b1;
        r = '{ST_EARLY_END, 8'd0, 15'd0, 1'b0, 7'd0, 1'b0, 1'b0, 1'b0};
      end
      ph = PH_HEADER;
      hdr_idx = HDR_IDX_FIRST;
    end
  endtask

  function automatic string run_text(disk_run_t r);
    return $sformatf("st=%0d byte=%02h cnt=%0d clip=%0b trk=%0d side=%0b tl=%0b il=%0b",
                     r.status, r.data_byte, r.repeat_count, r.run_clipped,
                     r.track_number, r.side_number, r.track_last, r.image_last);
  endfunction

  // ---------------------------------------------------------------- file builder
  task automatic put8(input logic [7:0] b);
    file_bytes.push_back(b);
  endtask

  task automatic put16(input logic [15:0] w);
    put8(w[15:8]);
    put8(w[7:0]);
  endtask

  task automatic put_header(input logic [15:0] id, input logic [15:0] sect,
                            input logic [15:0] sides, input logic [15:0] st,
                            input logic [15:0] en);
    put16(id);
    put16(sect);
    put16(sides);
    put16(st);
    put16(en);
  endtask

  // Send the first keep bytes of the file, flagging the last one.
  task automatic ship(input int unsigned keep, input bit hold);
    for (int unsigned i = 0; i < keep; i++)
      pend.push_back('{file_bytes[i], i == keep - 1, hold && i == 0});
    file_bytes.delete();
    files++;
  endtask

  task automatic put_track(input int unsigned sect);
    int unsigned room, cnt;
    logic [15:0] len;
    logic [7:0]  b;
    room = SECTOR_BYTES * sect;
    if (sect == 0) begin
      put16(16'($urandom));
      return;
    end
    if (sect == 1 && $urandom_range(0, 19) == 0) begin
      put16(16'(room));
      repeat (room) put8(8'($urandom));
      return;
    end
    len = 16'($urandom);
    if (len == room) len ^= 16'd1;
    put16(len);
    while (room > 0) begin
      if ($urandom_range(0, 9) < 4) begin
        do b = 8'($urandom); while (b == RUN_MARK);
        put8(b);
        room--;
      end else begin
        case ($urandom_range(0, 9))
          0: cnt = 0;
          1, 2, 3: cnt = $urandom_range(1, (room < 16) ? room : 16);
          4, 5: cnt = room;
          6: cnt = $urandom_range(room, 16'hFFFF);
          7: cnt = 16'hFFFF;
          default: cnt = $urandom_range(1, room);
        endcase
        put8(RUN_MARK);
        put8(8'($urandom));
        put16(16'(cnt));
        room -= (cnt > room) ? room : cnt;
      end
    end
  endtask

  task automatic make_image();
    int unsigned sect, sides, st, en;
    case ($urandom_range(0, 9))
      0: sect = 0;
      1, 2, 3, 4, 5: sect = $urandom_range(1, 4);
      9: sect = MAX_SECTORS;
      default: sect = $urandom_range(5, MAX_SECTORS);
    endcase
    sides = $urandom_range(0, 1);
    case ($urandom_range(0, 5))
      0: st = 0;
      1: st = MAX_END_TRACK;
      default: st = $urandom_range(0, MAX_END_TRACK);
    endcase
    en = st + $urandom_range(0, 2);
    if (en > MAX_END_TRACK) en = MAX_END_TRACK;
    put_header(MSA_ID, 16'(sect), 16'(sides), 16'(st), 16'(en));
    repeat ((en - st + 1) * (sides + 1)) put_track(sect);
  endtask

  task automatic make_bad_header();
    logic [15:0] id;
    int unsigned sect, sides, st, en;
    id = MSA_ID;
    sect = $urandom_range(0, MAX_SECTORS);
    sides = $urandom_range(0, 1);
    st = $urandom_range(0, MAX_END_TRACK);
    en = $urandom_range(st, MAX_END_TRACK);
    case ($urandom_range(0, 5))
      0: do id = 16'($urandom); while (id == MSA_ID);
      1: sect = $urandom_range(MAX_SECTORS + 1, 16'hFFFF);
      2: sides = $urandom_range(2, 16'hFFFF);
      3: st = $urandom_range(MAX_END_TRACK + 1, 16'hFFFF);
      4: en = $urandom_range(MAX_END_TRACK + 1, 16'hFFFF);
      default: begin
        st = $urandom_range(1, MAX_END_TRACK);
        en = $urandom_range(0, st - 1);
      end
    endcase
    put_header(id, 16'(sect), 16'(sides), 16'(st), 16'(en));
    repeat ($urandom_range(0, 4)) put8(8'($urandom));
  endtask

  // ---------------------------------------------------------------- byte driver
  always @(negedge clk) begin : feed_bytes
    file_byte_t nxt;
    if ($urandom_range(0, 199) == 0) in_rate = $urandom_range(0, 4);
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_took) begin
      if (in_gap != 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (pend.size() == 0 || (pend[0].hold && runs_due.size() != 0)) begin
        in_ch.valid <= 1'b0;
      end else if (pend.size() > QUIET_TAIL && in_rate != 0 &&
                   $urandom_range(0, 15) < in_rate) begin
        in_gap = $urandom_range(0, 14);
        in_ch.valid <= 1'b0;
      end else begin
        nxt = pend.pop_front();
        in_ch.in_byte   <= nxt.data;
        in_ch.file_last <= nxt.last;
        in_ch.valid     <= 1'b1;
      end
    end
  end

  always @(negedge clk) begin : take_runs
    if ($urandom_range(0, 199) == 0) out_rate = $urandom_range(0, 4);
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap != 0) begin
      out_gap--;
      out_ch.ready <= 1'b0;
    end else if (pend.size() > QUIET_TAIL && out_rate != 0 &&
                 $urandom_range(0, 15) < out_rate) begin
      out_gap = $urandom_range(0, 14);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- monitor
  always @(posedge clk) begin : watch
    disk_run_t seen, want, pred;
    bit        made, in_fire, out_fire;
    if (rst_n) begin
      in_fire  = in_ch.valid && in_ch.ready;
      out_fire = out_ch.valid && out_ch.ready;
      in_took <= in_fire;
      // check before predicting: a result never belongs to this edge's byte
      if (out_fire) begin
        seen = '{out_ch.status, out_ch.data_byte, out_ch.repeat_count, out_ch.run_clipped,
                 out_ch.track_number, out_ch.side_number, out_ch.track_last,
                 out_ch.image_last};
        runs_out++;
        if (runs_due.size() == 0) begin
          if (fails < 10) $display("%0t: unexpected result %s", $realtime, run_text(seen));
          fails++;
        end else begin
          want = runs_due.pop_front();
          if (seen !== want) begin
            if (fails < 10) begin
              $display("%0t: result mismatch", $realtime);
              $display("  expected %s", run_text(want));
              $display("  actual   %s", run_text(seen));
            end
            fails++;
          end
        end
      end
      if (in_fire) begin
        bytes_in++;
        decode_byte(in_ch.in_byte, in_ch.file_last, made, pred);
        if (made) begin
          runs_due.push_back(pred);
          case (pred.status)
            ST_DATA: begin
              n_data++;
              if (pred.run_clipped) n_clip++;
            end
            ST_BAD_HEADER: n_bad++;
            ST_EARLY_END:  n_early++;
            default:       n_empty++;
          endcase
        end
      end
      if (in_fire || out_fire) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles, %0d results outstanding",
                 $realtime, quiet_cycles, runs_due.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------- stimulus
  initial begin : stimulus
    int unsigned keep, pick;
    bit          hold;
    in_ch.valid = 1'b0;
    in_ch.in_byte = 8'd0;
    in_ch.file_last = 1'b0;
    out_ch.ready = 1'b0;

    // one-byte file: too short for a header
    put8(8'hFF);
    ship(1, 1'b0);
    // zero sectors: the length word alone closes the image
    put_header(MSA_ID, 16'd0, 16'd0, 16'd0, 16'd0);
    put16(16'hFFFF);
    ship(file_bytes.size(), 1'b0);
    // last track, one run far past the track end, file ends on it
    put_header(MSA_ID, 16'd1, 16'd0, 16'(MAX_END_TRACK), 16'(MAX_END_TRACK));
    put16(16'h0000);
    put8(RUN_MARK);
    put8(8'h00);
    put16(16'hFFFF);
    ship(file_bytes.size(), 1'b0);

    hold = 1'b1;
    while (pend.size() < ITEM_TARGET) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        make_image();
        if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 6)) put8(8'($urandom));
        keep = file_bytes.size();
        if ($urandom_range(0, 7) == 0) keep = $urandom_range(11, keep - 1);
      end else if (pick < 80) begin
        make_image();
        keep = $urandom_range(1, 10);
      end else if (pick < 93) begin
        make_bad_header();
        keep = file_bytes.size();
      end else begin
        repeat ($urandom_range(1, 24)) put8(8'($urandom));
        keep = file_bytes.size();
      end
      ship(keep, hold);
      hold = ($urandom_range(0, 9) == 0);
    end

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pend.size() != 0 || in_ch.valid) @(posedge clk);
    while (runs_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (runs_due.size() != 0) begin
      $display("%0d expected results never arrived", runs_due.size());
      fails++;
    end
    $display("Streamed %0d bytes in %0d files; %0d results checked, %0d failures.",
             bytes_in, files, runs_out, fails);
    $display("Covered %0d data runs (%0d clipped), %0d bad headers,",
             n_data, n_clip, n_bad);
    $display("  %0d early ends, %0d empty images.", n_early, n_empty);
    if (fails == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// ===== msa_track_rle_decoder.f =====
rtl/msa_trd_pkg.sv
rtl/msa_trd_if.sv
rtl/msa_track_rle_decoder.sv
verif/tb_msa_track_rle_decoder.sv
